// ----- design/tfce_pkg.sv -----
// Shared types and constants for the tire friction circle estimator.
// Used by tfce_axle, tfce_lane and the top level; depends on nothing.
package tfce_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_MASS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CG_FRONT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CG_REAR  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WHEELBASE = 2'd3;

	localparam int DIFF_W = 17;
	localparam int W_W    = 24;
	localparam int MV_W   = 26;
	localparam int P_W    = 50;
	localparam int MT_W   = 47;
	localparam int PROD_W = 62;
	localparam int NUM_W  = 63;
	localparam int DVD_W  = 46;
	localparam int CNT_W  = 6;
	localparam int REM_W  = 13;
	localparam int LAT_W  = 20;
	localparam int F_W    = 17;
	localparam int ROOT_W = 35;
	localparam int MX2_W  = 34;
	localparam int N2_W   = 40;
	localparam int RND_SH = 17;
	localparam int DEN_SH = 18;
	localparam int MAX_SH = 14;

	localparam logic signed [W_W-1:0]  SLIP_SCALE = 24'sd100;
	localparam logic signed [MT_W-1:0] M_SCALE    = 47'sd8000;
	localparam logic [F_W-1:0]         F_MAX      = 17'h1FFFF;
	localparam logic [DVD_W-1:0]       LAT_POS_LIM = 46'd524287;
	localparam logic [DVD_W-1:0]       LAT_NEG_LIM = 46'd524288;
	localparam logic signed [LAT_W-1:0] LAT_MAX   = 20'sh7FFFF;
	localparam logic signed [LAT_W-1:0] LAT_MIN   = 20'sh80000;

	typedef enum logic [2:0] {
		T_IDLE, T_P1, T_P2, T_AXS, T_AXLE, T_LGO, T_LANE, T_HOLD
	} top_state_t;

	typedef enum logic [1:0] {
		AX_IDLE, AX_PREP, AX_DIV, AX_SAT
	} axle_state_t;

	typedef enum logic [1:0] {
		L_IDLE, L_SQ, L_CMP, L_ROOT
	} lane_state_t;

	typedef struct packed {
		logic [F_W-1:0] max_force;
		logic [F_W-1:0] spare;
		logic           over;
	} lane_res_t;

endpackage

// ----- design/tfce_if.sv -----
// Valid/ready channel interfaces for sample words and result words.
// Depends on nothing.
interface tfce_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] turn_rate;
	logic signed [15:0] slip_angle;
	logic [15:0]        vehicle_speed;
	logic signed [15:0] desired_yaw_moment;
	logic [14:0]        mu_front_left;
	logic [14:0]        mu_front_right;
	logic [14:0]        mu_rear_left;
	logic [14:0]        mu_rear_right;
	logic [15:0]        load_front_left;
	logic [15:0]        load_front_right;
	logic [15:0]        load_rear_left;
	logic [15:0]        load_rear_right;

	modport source(output valid, turn_rate, slip_angle, vehicle_speed, desired_yaw_moment,
		mu_front_left, mu_front_right, mu_rear_left, mu_rear_right,
		load_front_left, load_front_right, load_rear_left, load_rear_right,
		input ready);
	modport sink(input valid, turn_rate, slip_angle, vehicle_speed, desired_yaw_moment,
		mu_front_left, mu_front_right, mu_rear_left, mu_rear_right,
		load_front_left, load_front_right, load_rear_left, load_rear_right,
		output ready);
endinterface

interface tfce_out_if;
	logic               valid;
	logic               ready;
	logic [16:0]        max_force_front_left;
	logic [16:0]        max_force_front_right;
	logic [16:0]        max_force_rear_left;
	logic [16:0]        max_force_rear_right;
	logic signed [19:0] lateral_need_front;
	logic signed [19:0] lateral_need_rear;
	logic [16:0]        spare_force_front_left;
	logic [16:0]        spare_force_front_right;
	logic [16:0]        spare_force_rear_left;
	logic [16:0]        spare_force_rear_right;
	logic [3:0]         overload_mask;

	modport source(output valid, max_force_front_left, max_force_front_right,
		max_force_rear_left, max_force_rear_right, lateral_need_front, lateral_need_rear,
		spare_force_front_left, spare_force_front_right, spare_force_rear_left,
		spare_force_rear_right, overload_mask, input ready);
	modport sink(input valid, max_force_front_left, max_force_front_right,
		max_force_rear_left, max_force_rear_right, lateral_need_front, lateral_need_rear,
		spare_force_front_left, spare_force_front_right, spare_force_rear_left,
		spare_force_rear_right, overload_mask, output ready);
endinterface

// ----- design/tfce_axle.sv -----
// Per-axle lateral need: moment-arm multiply, rounding and a bit-serial divider.
// Depends on tfce_pkg.
module tfce_axle import tfce_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [P_W-1:0]   p,
	input  logic [11:0]             arm,
	input  logic signed [MT_W-1:0]  mterm,
	input  logic [12:0]             wb,
	output logic                    busy,
	output logic signed [LAT_W-1:0] need
);

	axle_state_t state_q, state_d;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [MT_W-1:0]   mterm_q;
	logic [12:0]              wb_q;
	logic [DVD_W-1:0]         dvd_q;
	logic [REM_W-1:0]         rem_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     neg_q;
	logic signed [LAT_W-1:0]  need_q;

	logic signed [NUM_W-1:0] num;
	logic [NUM_W-1:0]        mag;
	logic [NUM_W:0]          mag2;
	logic [REM_W:0]          rem_n;
	logic                    qbit;

	always_comb begin
		num   = NUM_W'(prod_q) + NUM_W'(mterm_q);
		mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		// Adding half the divisor before the floor gives round half away from zero.
		mag2  = (NUM_W+1)'(mag) + ((NUM_W+1)'(wb_q) << RND_SH);
		rem_n = {rem_q, dvd_q[DVD_W-1]};
		qbit  = rem_n >= (REM_W+1)'(wb_q);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			AX_IDLE: if (start) state_d = AX_PREP;
			AX_PREP: state_d = AX_DIV;
			AX_DIV:  if (cnt_q == CNT_W'(1)) state_d = AX_SAT;
			AX_SAT:  state_d = AX_IDLE;
			default: state_d = AX_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= AX_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			AX_IDLE: begin
				if (start) begin
					prod_q  <= PROD_W'(p) * PROD_W'($signed({1'b0, arm}));
					mterm_q <= mterm;
					wb_q    <= wb;
				end
			end
			AX_PREP: begin
				neg_q <= num[NUM_W-1];
				dvd_q <= mag2[NUM_W:DEN_SH];
				rem_q <= '0;
				cnt_q <= CNT_W'(DVD_W);
			end
			AX_DIV: begin
				rem_q <= qbit ? REM_W'(rem_n - (REM_W+1)'(wb_q)) : rem_n[REM_W-1:0];
				dvd_q <= {dvd_q[DVD_W-2:0], qbit};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			AX_SAT: begin
				if (neg_q)
					need_q <= (dvd_q > LAT_NEG_LIM) ? LAT_MIN : $signed(-dvd_q[LAT_W-1:0]);
				else
					need_q <= (dvd_q > LAT_POS_LIM) ? LAT_MAX : $signed(dvd_q[LAT_W-1:0]);
			end
			default: ;
		endcase
	end

	assign busy = state_q != AX_IDLE;
	assign need = need_q;

endmodule

// ----- design/tfce_lane.sv -----
// One wheel lane: maximum force from mu and load, then the friction-circle
// spare force by a digit-by-digit square root. Depends on tfce_pkg.
module tfce_lane import tfce_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [14:0]      mu,
	input  logic [15:0]      load,
	input  logic             go,
	input  logic [LAT_W-1:0] nmag,
	output logic             busy,
	output lane_res_t        res
);

	lane_state_t state_q, state_d;
	logic [F_W-1:0]    max_q;
	logic [MX2_W-1:0]  mx2_q;
	logic [N2_W-1:0]   n2_q;
	logic [ROOT_W-1:0] x_q, root_q, bit_q;
	logic [F_W-1:0]    spare_q;
	logic              over_q;

	logic [31:0]       mprod;
	logic [17:0]       mshift;
	logic [ROOT_W-1:0] trial, root_n;
	logic              take;

	always_comb begin
		mprod  = 32'(mu) * 32'(load) + 32'd8192;
		mshift = mprod[31:MAX_SH];
		trial  = root_q + bit_q;
		take   = x_q >= trial;
		root_n = take ? (root_q >> 1) + bit_q : root_q >> 1;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			L_IDLE: if (go) state_d = L_SQ;
			L_SQ:   state_d = L_CMP;
			L_CMP:  state_d = (n2_q > N2_W'(mx2_q)) ? L_IDLE : L_ROOT;
			L_ROOT: if (bit_q == ROOT_W'(1)) state_d = L_IDLE;
			default: state_d = L_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= L_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (start)
			max_q <= (mshift > 18'(F_MAX)) ? F_MAX : mshift[F_W-1:0];
		case (state_q)
			L_SQ: begin
				mx2_q <= MX2_W'(max_q) * MX2_W'(max_q);
				n2_q  <= N2_W'(nmag) * N2_W'(nmag);
			end
			L_CMP: begin
				// The lateral need outside the circle leaves no spare force.
				if (n2_q > N2_W'(mx2_q)) begin
					spare_q <= '0;
					over_q  <= 1'b1;
				end else begin
					over_q <= 1'b0;
					x_q    <= ROOT_W'(mx2_q - n2_q[MX2_W-1:0]);
					root_q <= '0;
					bit_q  <= ROOT_W'(1) << (MX2_W - 2);
				end
			end
			L_ROOT: begin
				if (take) x_q <= x_q - trial;
				root_q <= root_n;
				bit_q  <= bit_q >> 2;
				if (bit_q == ROOT_W'(1)) spare_q <= root_n[F_W-1:0];
			end
			default: ;
		endcase
	end

	assign busy          = state_q != L_IDLE;
	assign res.max_force = max_q;
	assign res.spare     = spare_q;
	assign res.over      = over_q;

endmodule

// ----- design/tire_friction_circle_estimator_top.sv -----
// Top level of the tire friction circle estimator.
// Depends on tfce_pkg, tfce_if, tfce_axle and tfce_lane.
//
// One sample word is taken at a time. Its result word is presented once the
// sample has gone through these steps: states T_P1, T_P2 and T_AXS form the
// lateral body force and start the axles, the two axle units each run a 46-step
// bit-serial divider between a setup and a saturation state, and the four wheel
// lanes then each run setup states L_SQ and L_CMP and, unless the need lies
// outside the circle, a 17-step square root. The next sample can be taken in
// the cycle after the result is loaded; a result that is not yet taken holds
// the following one back. A finished result sits in the output register while
// the next sample is taken. The slip rate uses the body slip of the previous
// sample, zero after reset. Configuration is written through cfg_we, cfg_index
// and cfg_data; the user must do so only while idle, which the block does not
// enforce. A wheelbase of zero acts as one millimeter.
module tire_friction_circle_estimator_top import tfce_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	tfce_in_if.sink               samples,
	tfce_out_if.source            results,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	top_state_t state_q, state_d;
	logic [9:0]  mass_q;
	logic [11:0] cg_front_q, cg_rear_q;
	logic [12:0] wb_q;
	logic signed [15:0] last_slip_q;

	logic signed [15:0]       yaw_q, m_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic [15:0]              speed_q;
	logic signed [W_W-1:0]    w_q;
	logic [MV_W-1:0]          mv_q;
	logic signed [P_W-1:0]    p_q;
	logic signed [MT_W-1:0]   mterm_q;

	logic accept, ax_start, lane_go, out_load;
	logic signed [LAT_W-1:0] need_f, need_r;
	logic [LAT_W-1:0] nmag_f, nmag_r;
	logic [12:0] wb_eff;
	logic [3:0] lane_busy;
	logic ax_busy_f, ax_busy_r;
	lane_res_t lres [4];
	logic [14:0] mu_in [4];
	logic [15:0] load_in [4];
	logic [LAT_W-1:0] nmag_in [4];
	logic out_valid_q;

	assign accept = samples.valid && samples.ready;
	assign wb_eff = (wb_q == 13'd0) ? 13'd1 : wb_q;
	assign nmag_f = need_f[LAT_W-1] ? LAT_W'(-need_f) : LAT_W'(need_f);
	assign nmag_r = need_r[LAT_W-1] ? LAT_W'(-need_r) : LAT_W'(need_r);

	always_comb begin
		state_d       = state_q;
		samples.ready = 1'b0;
		ax_start      = 1'b0;
		lane_go       = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			T_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) state_d = T_P1;
			end
			T_P1: state_d = T_P2;
			T_P2: state_d = T_AXS;
			T_AXS: begin
				ax_start = 1'b1;
				state_d  = T_AXLE;
			end
			T_AXLE: if (!ax_busy_f && !ax_busy_r) state_d = T_LGO;
			T_LGO: begin
				lane_go = 1'b1;
				state_d = T_LANE;
			end
			T_LANE: if (lane_busy == 4'd0) state_d = T_HOLD;
			T_HOLD: begin
				if (!out_valid_q || results.ready) begin
					out_load = 1'b1;
					state_d  = T_IDLE;
				end
			end
			default: state_d = T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			mass_q      <= 10'd300;
			cg_front_q  <= 12'd765;
			cg_rear_q   <= 12'd765;
			wb_q        <= 13'd1530;
			last_slip_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_MASS:      mass_q     <= cfg_data[9:0];
					CFG_CG_FRONT:  cg_front_q <= cfg_data[11:0];
					CFG_CG_REAR:   cg_rear_q  <= cfg_data[11:0];
					CFG_WHEELBASE: wb_q       <= cfg_data;
					default: ;
				endcase
			end
			if (accept) last_slip_q <= samples.slip_angle;
			if (out_load) out_valid_q <= 1'b1;
			else if (results.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			yaw_q   <= samples.turn_rate;
			diff_q  <= DIFF_W'(samples.slip_angle) - DIFF_W'(last_slip_q);
			speed_q <= samples.vehicle_speed;
			m_q     <= samples.desired_yaw_moment;
		end
		if (state_q == T_P1) begin
			w_q  <= W_W'(yaw_q) - W_W'(diff_q) * SLIP_SCALE;
			mv_q <= MV_W'(mass_q) * MV_W'(speed_q);
		end
		if (state_q == T_P2) begin
			p_q     <= P_W'($signed({1'b0, mv_q})) * P_W'(w_q);
			mterm_q <= (MT_W'(m_q) * M_SCALE) <<< RND_SH;
		end
		if (out_load) begin
			results.max_force_front_left    <= lres[0].max_force;
			results.max_force_front_right   <= lres[1].max_force;
			results.max_force_rear_left     <= lres[2].max_force;
			results.max_force_rear_right    <= lres[3].max_force;
			results.spare_force_front_left  <= lres[0].spare;
			results.spare_force_front_right <= lres[1].spare;
			results.spare_force_rear_left   <= lres[2].spare;
			results.spare_force_rear_right  <= lres[3].spare;
			results.lateral_need_front      <= need_f;
			results.lateral_need_rear       <= need_r;
			results.overload_mask <= {lres[3].over, lres[2].over, lres[1].over, lres[0].over};
		end
	end

	assign results.valid = out_valid_q;

	// The yaw moment term pushes the front axle and pulls the rear one.
	tfce_axle u_axle_front (
		.clk(clk), .arst_n(arst_n), .start(ax_start), .p(p_q), .arm(cg_rear_q),
		.mterm(mterm_q), .wb(wb_eff), .busy(ax_busy_f), .need(need_f)
	);

	tfce_axle u_axle_rear (
		.clk(clk), .arst_n(arst_n), .start(ax_start), .p(p_q), .arm(cg_front_q),
		.mterm(-mterm_q), .wb(wb_eff), .busy(ax_busy_r), .need(need_r)
	);

	assign mu_in[0]   = samples.mu_front_left;
	assign mu_in[1]   = samples.mu_front_right;
	assign mu_in[2]   = samples.mu_rear_left;
	assign mu_in[3]   = samples.mu_rear_right;
	assign load_in[0] = samples.load_front_left;
	assign load_in[1] = samples.load_front_right;
	assign load_in[2] = samples.load_rear_left;
	assign load_in[3] = samples.load_rear_right;
	assign nmag_in[0] = nmag_f;
	assign nmag_in[1] = nmag_f;
	assign nmag_in[2] = nmag_r;
	assign nmag_in[3] = nmag_r;

	for (genvar k = 0; k < 4; k++) begin : g_lane
		tfce_lane u_lane (
			.clk(clk), .arst_n(arst_n), .start(accept), .mu(mu_in[k]), .load(load_in[k]),
			.go(lane_go), .nmag(nmag_in[k]), .busy(lane_busy[k]), .res(lres[k])
		);
	end

endmodule

// ----- design/tfce_checker.sv -----
// Port-level checks for the tire friction circle estimator, bound to the top.
// Depends on tfce_if through the bound ports.
module tfce_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [16:0] max_fl,
	input logic [16:0] spare_fl,
	input logic [3:0]  mask
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(spare_fl) && $stable(mask))
		else $error("result word changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second sample taken while one is in work");

	a_overload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mask[0] |-> spare_fl == 17'd0)
		else $error("overloaded wheel reports spare force");

	a_spare_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> spare_fl <= max_fl)
		else $error("spare force above maximum force");

endmodule

bind tire_friction_circle_estimator_top tfce_checker u_tfce_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(samples.valid), .in_ready(samples.ready),
	.out_valid(results.valid), .out_ready(results.ready),
	.max_fl(results.max_force_front_left), .spare_fl(results.spare_force_front_left),
	.mask(results.overload_mask)
);
